>>> hdl/taf_pkg.sv
// Shared constants, types and register codes for the throttle averaging failsafe.
package taf_pkg;

  // Item geometry
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned DIGIT_W   = 8;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned SCALED_W  = VALUE_W + 1;

  // Averaging window
  localparam int unsigned WINDOW_LEN = 10;
  localparam int unsigned SUM_W      = 20;
  localparam int unsigned CNT_W      = 4;
  localparam logic [CNT_W-1:0] WIN_LEN_C = CNT_W'(WINDOW_LEN);

  // Divide by WINDOW_LEN as multiply by rounded-up reciprocal; exact for SUM_W-bit sums
  localparam int unsigned DIV_SHIFT = 24;
  localparam int unsigned DIV_MUL_W = DIV_SHIFT + 1;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL =
    DIV_MUL_W'((2**DIV_SHIFT + WINDOW_LEN - 1) / WINDOW_LEN);
  localparam int unsigned PROD_W = SUM_W + DIV_MUL_W;

  // Digit conversion
  localparam logic [VALUE_W-1:0] ASCII_ZERO = VALUE_W'(48);
  localparam logic [VALUE_W-1:0] LANE_WEIGHT [NUM_LANES] =
    '{VALUE_W'(1000), VALUE_W'(100), VALUE_W'(10), VALUE_W'(1)};

  // Link-loss counter saturation
  localparam logic [LEVEL_W-1:0] LOSS_SAT = LEVEL_W'(65500);

  // Register reset values
  localparam logic [LEVEL_W-1:0] IDLE_LEVEL_RST = LEVEL_W'(2636);
  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST  = LEVEL_W'(2000);
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST  = LEVEL_W'(3500);
  localparam logic [LEVEL_W-1:0] HOLD_COUNT_RST = LEVEL_W'(100);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_LEVEL = 2'd0,
    CFG_MIN_LEVEL  = 2'd1,
    CFG_MAX_LEVEL  = 2'd2,
    CFG_HOLD_COUNT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] idle_level;
    logic [LEVEL_W-1:0] min_level;
    logic [LEVEL_W-1:0] max_level;
    logic [LEVEL_W-1:0] hold_count;
  } cfg_t;

  // Per-lane weighted digit terms
  typedef logic [NUM_LANES-1:0][VALUE_W-1:0] lane_terms_t;

  // What the window pipeline hands to the failsafe stage
  typedef struct packed {
    logic                close;
    logic                lost;
    logic [SCALED_W-1:0] scaled;
  } win_t;

endpackage

>>> hdl/taf_lane.sv
// One digit lane: ASCII byte to weighted decimal term, wrapping at 16 bits.
module taf_lane import taf_pkg::*; (
  input  logic [DIGIT_W-1:0] digit_i,
  input  logic [VALUE_W-1:0] weight_i,
  output logic [VALUE_W-1:0] term_o
);

  logic [VALUE_W-1:0] digit_val;

  // Remove ASCII offset, then scale by the lane's decimal weight
  assign digit_val = VALUE_W'(digit_i) - ASCII_ZERO;
  assign term_o    = VALUE_W'(digit_val * weight_i);

endmodule

>>> hdl/taf_window.sv
// Lane merge, window accumulation and mean/scale pipeline.
module taf_window import taf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  lane_terms_t terms_i,
  input  logic        lost_i,
  output logic        ready_o,
  output logic        valid_o,
  output win_t        win_o,
  input  logic        ready_i
);

  // Stage valids and ready chain
  logic v2_q, v3_q, v4_q, v5_q;
  logic rdy2, rdy3, rdy4, rdy5;

  // Stage payloads
  logic [VALUE_W-1:0]  val2_q;
  logic                lost2_q, lost3_q, lost4_q, lost5_q;
  logic                close3_q, close4_q, close5_q;
  logic [SUM_W-1:0]    sum3_q;
  logic [PROD_W-1:0]   prod4_q;
  logic [SCALED_W-1:0] scaled5_q;

  // Window state
  logic [SUM_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [VALUE_W-1:0] merged;
  logic [SUM_W-1:0]   acc_sum;
  logic [CNT_W-1:0]   cnt_inc;
  logic               close;
  logic               take3;
  logic [VALUE_W-1:0] quot;

  assign rdy5    = !v5_q || ready_i;
  assign rdy4    = !v4_q || rdy5;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign ready_o = rdy2;
  assign take3   = v2_q && rdy3;

  // Merge: sum of lane terms, wrapping at 16 bits
  always_comb begin
    merged = '0;
    for (int unsigned i = 0; i < NUM_LANES; i++) begin
      merged = merged + terms_i[i];
    end
  end

  // Window accumulate and count
  assign acc_sum = acc_q + SUM_W'(val2_q);
  assign cnt_inc = cnt_q + CNT_W'(1);
  assign close   = cnt_inc >= WIN_LEN_C;

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (take3) begin
      if (close) begin
        acc_d = '0;
        cnt_d = '0;
      end else begin
        acc_d = acc_sum;
        cnt_d = cnt_inc;
      end
    end
  end

  // Quotient from reciprocal product
  assign quot = prod4_q[DIV_SHIFT +: VALUE_W];

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      if (rdy2) v2_q <= valid_i;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      val2_q  <= merged;
      lost2_q <= lost_i;
    end
    if (rdy3) begin
      sum3_q   <= acc_sum;
      close3_q <= close;
      lost3_q  <= lost2_q;
    end
    if (rdy4) begin
      prod4_q  <= PROD_W'(sum3_q) * PROD_W'(DIV_MUL);
      close4_q <= close3_q;
      lost4_q  <= lost3_q;
    end
    if (rdy5) begin
      scaled5_q <= SCALED_W'(quot) + SCALED_W'(quot >> 2);
      close5_q  <= close4_q;
      lost5_q   <= lost4_q;
    end
  end

  assign valid_o      = v5_q;
  assign win_o.close  = close5_q;
  assign win_o.lost   = lost5_q;
  assign win_o.scaled = scaled5_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < WIN_LEN_C)
    else $error("window count out of range");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take3 && close) |=> (cnt_q == '0 && acc_q == '0))
    else $error("window did not clear at close");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && !ready_i) |=> (v5_q && $stable(win_o)))
    else $error("window output changed while blocked");
`endif

endmodule

>>> hdl/taf_failsafe.sv
// Link-loss counter, compare select and clamp; holds the output register.
module taf_failsafe import taf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  win_t               win_i,
  input  cfg_t               cfg_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [LEVEL_W-1:0] compare_value_o
);

  logic                ov_q;
  logic [SCALED_W-1:0] scaled_q, scaled_d;
  logic [LEVEL_W-1:0]  loss_q, loss_d;
  logic [LEVEL_W-1:0]  cmp_q, cmp_d;

  logic                take;
  logic [SCALED_W-1:0] sm;
  logic [LEVEL_W-1:0]  loss_inc;
  logic [SCALED_W-1:0] cmp_sel;
  logic [SCALED_W-1:0] clamp_hi;

  assign ready_o = !ov_q || !out_stall_i;
  assign take    = valid_i && ready_o;

  // Scaled mean in effect for this transaction
  assign sm       = win_i.close ? win_i.scaled : scaled_q;
  assign loss_inc = loss_q + LEVEL_W'(1);

  // Compare source and loss counter
  always_comb begin
    cmp_sel = SCALED_W'(cmp_q);
    loss_d  = loss_q;
    if (win_i.lost) begin
      cmp_sel = (loss_inc >= cfg_i.hold_count) ? SCALED_W'(cfg_i.idle_level) : sm;
      loss_d  = (loss_inc > LOSS_SAT) ? LOSS_SAT : loss_inc;
    end else if (win_i.close) begin
      cmp_sel = sm;
      loss_d  = '0;
    end
  end

  // Clamp: upper bound first, then lower bound wins
  assign clamp_hi = (cmp_sel > SCALED_W'(cfg_i.max_level)) ? SCALED_W'(cfg_i.max_level)
                                                            : cmp_sel;
  assign cmp_d    = (clamp_hi < SCALED_W'(cfg_i.min_level)) ? cfg_i.min_level
                                                             : clamp_hi[LEVEL_W-1:0];
  assign scaled_d = win_i.close ? win_i.scaled : scaled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q     <= 1'b0;
      scaled_q <= '0;
      loss_q   <= '0;
      cmp_q    <= '0;
    end else begin
      if (ready_o) ov_q <= valid_i;
      if (take) begin
        scaled_q <= scaled_d;
        loss_q   <= loss_d;
        cmp_q    <= cmp_d;
      end
    end
  end

  assign out_valid_o     = ov_q;
  assign compare_value_o = cmp_q;

`ifndef SYNTHESIS
  a_loss_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loss_q <= LOSS_SAT)
    else $error("loss counter above saturation");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> ($stable(loss_q) && $stable(cmp_q)))
    else $error("failsafe state changed without a transaction");

  a_link_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && win_i.close && !win_i.lost) |=> (loss_q == '0))
    else $error("loss counter not cleared at window close with link up");
`endif

endmodule

>>> hdl/throttle_average_failsafe.sv
// Top level: digit lanes, window/mean pipeline, failsafe stage and config registers.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+-----------------------------------------
//  in      | in_valid_i / in_stall_o     | digit_*_i (4 x 8b), link_lost_i
//  out     | out_valid_o / out_stall_i   | compare_value_o (16b)
//  cfg     | cfg_we_i                    | cfg_idx_i (2b), cfg_data_i (16b)
//
// One transaction per cycle sustained while the output is not stalled.
// The failsafe stage's compare/loss feedback runs through its own registers and keeps up with that rate.
// Reset sets the config registers to their defaults and clears all window and failsafe state.
// Each stage holds while the next is full and blocked; empty stages still fill, so input
// is taken until the first stage is occupied and cannot move.
module throttle_average_failsafe import taf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [DIGIT_W-1:0]   digit_thousands_i,
  input  logic [DIGIT_W-1:0]   digit_hundreds_i,
  input  logic [DIGIT_W-1:0]   digit_tens_i,
  input  logic [DIGIT_W-1:0]   digit_ones_i,
  input  logic                 link_lost_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [LEVEL_W-1:0]   compare_value_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEVEL_W-1:0]   cfg_data_i
);

  logic [DIGIT_W-1:0] digits [NUM_LANES];
  lane_terms_t        terms;
  lane_terms_t        terms1_q;
  logic               lost1_q;
  logic               v1_q;
  logic               rdy1;
  logic               win_ready;
  logic               win_valid;
  win_t               win;
  logic               fs_ready;
  cfg_t               cfg_q;

  assign digits[0] = digit_thousands_i;
  assign digits[1] = digit_hundreds_i;
  assign digits[2] = digit_tens_i;
  assign digits[3] = digit_ones_i;

  // Digit lanes
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    taf_lane u_lane (
      .digit_i  (digits[g]),
      .weight_i (LANE_WEIGHT[g]),
      .term_o   (terms[g])
    );
  end

  // Lane output register
  assign rdy1       = !v1_q || win_ready;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      terms1_q <= terms;
      lost1_q  <= link_lost_i;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_level <= IDLE_LEVEL_RST;
      cfg_q.min_level  <= MIN_LEVEL_RST;
      cfg_q.max_level  <= MAX_LEVEL_RST;
      cfg_q.hold_count <= HOLD_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_IDLE_LEVEL: cfg_q.idle_level <= cfg_data_i;
        CFG_MIN_LEVEL:  cfg_q.min_level  <= cfg_data_i;
        CFG_MAX_LEVEL:  cfg_q.max_level  <= cfg_data_i;
        CFG_HOLD_COUNT: cfg_q.hold_count <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Merge, window and mean pipeline
  taf_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .terms_i (terms1_q),
    .lost_i  (lost1_q),
    .ready_o (win_ready),
    .valid_o (win_valid),
    .win_o   (win),
    .ready_i (fs_ready)
  );

  // Failsafe, clamp and output register
  taf_failsafe u_failsafe (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (win_valid),
    .win_i           (win),
    .cfg_i           (cfg_q),
    .ready_o         (fs_ready),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .compare_value_o (compare_value_o)
  );

endmodule

>>> tb/taf_compare_checker.sv
// Checker for the throttle averaging failsafe: predicts every compare value and matches results.
module taf_compare_checker import taf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [DIGIT_W-1:0]   digit_thousands_i,
  input  logic [DIGIT_W-1:0]   digit_hundreds_i,
  input  logic [DIGIT_W-1:0]   digit_tens_i,
  input  logic [DIGIT_W-1:0]   digit_ones_i,
  input  logic                 link_lost_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [LEVEL_W-1:0]   compare_value_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEVEL_W-1:0]   cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  // Shadow copy of the registers and of the averaging / failsafe state
  cfg_t                cfg_q;
  logic [SUM_W-1:0]    win_sum_q;
  logic [CNT_W-1:0]    win_cnt_q;
  logic [VALUE_W-1:0]  mean_q;
  logic [LEVEL_W-1:0]  loss_cnt_q;
  logic [LEVEL_W-1:0]  compare_q;

  // Compare values owed by the block, oldest first
  logic [LEVEL_W-1:0]  compare_expected_q [$];

  // Advance the shadow state by one transaction and give the compare value it produces
  task automatic advance_throttle(
    input  logic [DIGIT_W-1:0] th,
    input  logic [DIGIT_W-1:0] hu,
    input  logic [DIGIT_W-1:0] te,
    input  logic [DIGIT_W-1:0] on,
    input  logic               lost,
    output logic [LEVEL_W-1:0] cmp_out
  );
    logic [VALUE_W-1:0]  sample;
    logic [SCALED_W-1:0] scaled;
    logic [SCALED_W-1:0] cmp;
    // 16-bit wrapping decimal conversion, any byte accepted
    sample = (VALUE_W'(th) - ASCII_ZERO) * VALUE_W'(1000)
           + (VALUE_W'(hu) - ASCII_ZERO) * VALUE_W'(100)
           + (VALUE_W'(te) - ASCII_ZERO) * VALUE_W'(10)
           + (VALUE_W'(on) - ASCII_ZERO);
    cmp = SCALED_W'(compare_q);
    win_sum_q = win_sum_q + SUM_W'(sample);
    win_cnt_q = win_cnt_q + 1'b1;

    // Window close: keep the truncated mean, restart the window
    if (win_cnt_q >= CNT_W'(WINDOW_LEN)) begin
      mean_q    = VALUE_W'(win_sum_q / SUM_W'(WINDOW_LEN));
      win_cnt_q = '0;
      win_sum_q = '0;
      if (!lost) begin
        cmp        = SCALED_W'(mean_q) + SCALED_W'(mean_q >> 2);
        loss_cnt_q = '0;
      end
    end

    // Failsafe: compare against hold first, saturate afterwards
    if (lost) begin
      scaled     = SCALED_W'(mean_q) + SCALED_W'(mean_q >> 2);
      loss_cnt_q = loss_cnt_q + 1'b1;
      if (loss_cnt_q >= cfg_q.hold_count) cmp = SCALED_W'(cfg_q.idle_level);
      else cmp = scaled;
      if (loss_cnt_q > LOSS_SAT) loss_cnt_q = LOSS_SAT;
    end

    // Clamp to max first, then min wins when the limits cross
    if (cmp > SCALED_W'(cfg_q.max_level)) cmp = SCALED_W'(cfg_q.max_level);
    if (cmp < SCALED_W'(cfg_q.min_level)) cmp = SCALED_W'(cfg_q.min_level);
    compare_q = cmp[LEVEL_W-1:0];
    cmp_out   = compare_q;
  endtask

  // Watch all three ports at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    logic [LEVEL_W-1:0] cmp_pred;
    logic [LEVEL_W-1:0] cmp_want;
    if (!rst_ni) begin
      cfg_q.idle_level = IDLE_LEVEL_RST;
      cfg_q.min_level  = MIN_LEVEL_RST;
      cfg_q.max_level  = MAX_LEVEL_RST;
      cfg_q.hold_count = HOLD_COUNT_RST;
      win_sum_q    = '0;
      win_cnt_q    = '0;
      mean_q       = '0;
      loss_cnt_q   = '0;
      compare_q    = '0;
      fail_count_o = 0;
      pending_o    = 0;
      compare_expected_q.delete();
    end else begin
      // Result transaction against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (compare_expected_q.size() == 0) begin
          $display("%0t: compare_value %0d arrived with nothing expected",
                   $time, compare_value_i);
          fail_count_o++;
        end else begin
          cmp_want = compare_expected_q.pop_front();
          if (compare_value_i !== cmp_want) begin
            $display("%0t: compare_value mismatch: expected %0d, actual %0d",
                     $time, cmp_want, compare_value_i);
            fail_count_o++;
          end
        end
      end

      // Input transaction
      if (in_valid_i && !in_stall_i) begin
        advance_throttle(digit_thousands_i, digit_hundreds_i, digit_tens_i,
                         digit_ones_i, link_lost_i, cmp_pred);
        compare_expected_q.push_back(cmp_pred);
      end

      // Register writes apply to later transactions
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_IDLE_LEVEL: cfg_q.idle_level = cfg_data_i;
          CFG_MIN_LEVEL:  cfg_q.min_level  = cfg_data_i;
          CFG_MAX_LEVEL:  cfg_q.max_level  = cfg_data_i;
          CFG_HOLD_COUNT: cfg_q.hold_count = cfg_data_i;
          default: ;
        endcase
      end

      pending_o = compare_expected_q.size();
    end
  end

endmodule

>>> tb/throttle_average_failsafe_tb.sv
// Testbench top for the throttle averaging failsafe: clock, reset, stimulus and verdict.
module throttle_average_failsafe_tb import taf_pkg::*;;

  localparam int unsigned QUIET_LIMIT    = 5000;
  localparam int unsigned HOLD_OFF_LEN   = 300;
  localparam int unsigned PHASE_ITEMS    = 305;
  localparam int unsigned OUTAGE_ITEMS   = 80;
  localparam int unsigned DRAIN_CYCLES   = 20;

  logic                 clk_i             = 1'b0;
  logic                 rst_ni            = 1'b0;
  logic                 in_valid_i        = 1'b0;
  logic                 in_stall_o;
  logic [DIGIT_W-1:0]   digit_thousands_i = '0;
  logic [DIGIT_W-1:0]   digit_hundreds_i  = '0;
  logic [DIGIT_W-1:0]   digit_tens_i      = '0;
  logic [DIGIT_W-1:0]   digit_ones_i      = '0;
  logic                 link_lost_i       = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i       = 1'b0;
  logic [LEVEL_W-1:0]   compare_value_o;
  logic                 cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i         = '0;
  logic [LEVEL_W-1:0]   cfg_data_i        = '0;

  int unsigned fail_count;
  int unsigned pending_cnt;

  // Traffic shaping knobs, set by the stimulus process
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_off_req  = 1'b0;

  // Random item shaping
  int unsigned item_count    = 0;
  int unsigned window_flavor = 0;
  int unsigned link_run_left = 0;
  bit          link_down     = 1'b0;
  int unsigned lost_span     = 10;

  throttle_average_failsafe u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .digit_thousands_i (digit_thousands_i),
    .digit_hundreds_i  (digit_hundreds_i),
    .digit_tens_i      (digit_tens_i),
    .digit_ones_i      (digit_ones_i),
    .link_lost_i       (link_lost_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .compare_value_o   (compare_value_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i)
  );

  taf_compare_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .digit_thousands_i (digit_thousands_i),
    .digit_hundreds_i  (digit_hundreds_i),
    .digit_tens_i      (digit_tens_i),
    .digit_ones_i      (digit_ones_i),
    .link_lost_i       (link_lost_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .compare_value_i   (compare_value_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .fail_count_o      (fail_count),
    .pending_o         (pending_cnt)
  );

  // 20-unit clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver: random stall, or a long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_LEN - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any transaction
  always @(posedge clk_i) begin
    int unsigned quiet_cycles;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // Offer one transaction; entered and left at a falling edge, valid left high
  task automatic send_item(
    input logic [DIGIT_W-1:0] th,
    input logic [DIGIT_W-1:0] hu,
    input logic [DIGIT_W-1:0] te,
    input logic [DIGIT_W-1:0] on,
    input logic               lost
  );
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    digit_thousands_i <= th;
    digit_hundreds_i  <= hu;
    digit_tens_i      <= te;
    digit_ones_i      <= on;
    link_lost_i       <= lost;
    do @(posedge clk_i); while (in_stall_o);
    item_count++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait for every owed result
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  // Write all four registers back to back
  task automatic apply_settings(
    input logic [LEVEL_W-1:0] idle,
    input logic [LEVEL_W-1:0] lo,
    input logic [LEVEL_W-1:0] hi,
    input logic [LEVEL_W-1:0] hold
  );
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IDLE_LEVEL;
    cfg_data_i <= idle;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_MIN_LEVEL;
    cfg_data_i <= lo;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_MAX_LEVEL;
    cfg_data_i <= hi;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_HOLD_COUNT;
    cfg_data_i <= hold;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    lost_span = (int'(hold) * 2 + 10 > 250) ? 250 : int'(hold) * 2 + 10;
  endtask

  // One digit byte, shaped by the flavor of the current window
  function automatic logic [DIGIT_W-1:0] pick_digit(input int unsigned lane);
    case (window_flavor)
      0: return DIGIT_W'($urandom_range(48, 57));
      1: return (lane == 0) ? DIGIT_W'($urandom_range(106, 113))
                            : DIGIT_W'($urandom_range(48, 57));
      2: return DIGIT_W'($urandom_range(255));
      default: return ($urandom_range(99) < 50) ? DIGIT_W'($urandom_range(48, 57))
                                                : DIGIT_W'($urandom_range(255));
    endcase
  endfunction

  // Random transaction with runs of link loss and occasional noise on the flag
  task automatic send_random();
    logic lost;
    if (item_count % WINDOW_LEN == 0) window_flavor = $urandom_range(3);
    if (link_run_left == 0) begin
      link_down     = !link_down;
      link_run_left = link_down ? $urandom_range(1, lost_span) : $urandom_range(1, 25);
    end
    link_run_left--;
    lost = ($urandom_range(99) < 5) ? 1'($urandom_range(1)) : link_down;
    send_item(pick_digit(0), pick_digit(1), pick_digit(2), pick_digit(3), lost);
  endtask

  // Stimulus and verdict
  initial begin
    logic [LEVEL_W-1:0] lo;
    logic [LEVEL_W-1:0] hi;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: full range, short hold
    send_idle_pct = 11;
    recv_idle_pct = 64;
    apply_settings(16'd1234, 16'd0, 16'hFFFF, 16'd3);
    repeat (4) send_item("q", "5", "3", "5", 1'b0);     // link up mid-window: holds
    send_item("q", "5", "3", "5", 1'b1);                // short loss: scaled old mean
    repeat (5) send_item("q", "5", "3", "5", 1'b0);     // window close, scaled mean > 16 bits
    send_item(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);        // lowest bytes
    send_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);        // highest bytes
    send_item("0", "0", "0", "0", 1'b1);                // reaches hold: idle level
    send_item("9", "9", "9", "9", 1'b1);
    send_item("9", "9", "9", "9", 1'b0);                // link back, not at window end
    send_item(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0);
    send_item(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0);
    send_item("1", "2", "3", "4", 1'b0);
    send_item("5", "6", "7", "8", 1'b0);
    send_item("0", "0", "0", "1", 1'b1);                // loss on a window close
    settle();

    // Directed: crossed limits, min wins
    apply_settings(16'd500, 16'd3000, 16'd1000, 16'd65500);
    send_item("2", "0", "0", "0", 1'b0);
    send_item("4", "0", "0", "0", 1'b1);
    send_item("0", "0", "0", "0", 1'b0);
    settle();

    // Long outage: loss counter runs past the hold count, then the link returns
    apply_settings(16'd777, 16'd0, 16'hFFFF, 16'd60);
    for (int unsigned i = 0; i < OUTAGE_ITEMS; i++) begin
      send_item(DIGIT_W'($urandom_range(48, 57)), DIGIT_W'($urandom_range(48, 57)),
                DIGIT_W'($urandom_range(48, 57)), DIGIT_W'($urandom_range(48, 57)), 1'b1);
    end
    repeat (2 * WINDOW_LEN) send_item("1", "5", "0", "0", 1'b0);
    settle();

    // Random phases under changing settings and traffic
    for (int unsigned ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 11 : (ph < 4) ? 64 : 0;
      recv_idle_pct = (ph < 2) ? 64 : (ph < 4) ? 11 : 0;
      case (ph)
        0, 4: begin
          lo = LEVEL_W'($urandom_range(0, 4000));
          hi = LEVEL_W'($urandom_range(lo, 65535));
          apply_settings(LEVEL_W'($urandom), lo, hi, LEVEL_W'($urandom_range(0, 40)));
          hold_off_req = 1'b1;
        end
        1: apply_settings(16'd0, 16'd0, 16'hFFFF, 16'd0);
        2: begin
          lo = LEVEL_W'($urandom_range(1000, 65535));
          hi = LEVEL_W'($urandom_range(0, lo - 1));
          apply_settings(LEVEL_W'($urandom), lo, hi, LEVEL_W'($urandom_range(1, 20)));
        end
        3: apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'd1);
        default: apply_settings(IDLE_LEVEL_RST, MIN_LEVEL_RST, MAX_LEVEL_RST,
                                HOLD_COUNT_RST);
      endcase
      repeat (PHASE_ITEMS) send_random();
      settle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/taf_pkg.sv
hdl/taf_lane.sv
hdl/taf_window.sv
hdl/taf_failsafe.sv
hdl/throttle_average_failsafe.sv
tb/taf_compare_checker.sv
tb/throttle_average_failsafe_tb.sv
